// ----- rtl/core/sfd_pkg.sv -----
package sfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CFG_INDEX_W = 2;

  // Seed of the running checksum and the bytes counted by the length before payload.
  localparam logic [BYTE_W-1:0] CHECK_SEED   = 8'hFF;
  localparam logic [BYTE_W-1:0] HEADER_BYTES = 8'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NAK     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_VALUE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NAK_VALUE    = 2'd2;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd1;
  localparam logic [BYTE_W-1:0] ACK_VALUE_RST    = 8'd6;
  localparam logic [BYTE_W-1:0] NAK_VALUE_RST    = 8'd21;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] ack_value;
    logic [BYTE_W-1:0] nak_value;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] msg_type;
    logic [BYTE_W-1:0] function_id;
    logic [BYTE_W-1:0] reply_byte;
    logic              frame_end;
  } res_t;

endpackage

// ----- rtl/core/sfd_cfg.sv -----
module sfd_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]          cfg_data,
  output sfd_pkg::cfg_t                       cfg
);

  sfd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= sfd_pkg::START_MARKER_RST;
      cfg_r.ack_value    <= sfd_pkg::ACK_VALUE_RST;
      cfg_r.nak_value    <= sfd_pkg::NAK_VALUE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfd_pkg::REG_START_MARKER: cfg_r.start_marker <= cfg_data;
        sfd_pkg::REG_ACK_VALUE:    cfg_r.ack_value    <= cfg_data;
        sfd_pkg::REG_NAK_VALUE:    cfg_r.nak_value    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sfd_parse.sv -----
module sfd_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
  input  sfd_pkg::cfg_t               cfg,
  output logic                        res_valid,
  output sfd_pkg::res_t               res
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_FUNC    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [sfd_pkg::BYTE_W-1:0]  len_r, len_nxt;
  logic [sfd_pkg::BYTE_W-1:0]  seen_r, seen_nxt;
  logic [sfd_pkg::BYTE_W-1:0]  check_r, check_nxt;
  logic [sfd_pkg::BYTE_W-1:0]  type_r, type_nxt;
  logic [sfd_pkg::BYTE_W-1:0]  func_r, func_nxt;
  logic [sfd_pkg::BYTE_W-1:0]  seen_inc;
  logic [sfd_pkg::BYTE_W:0]    seen_total;
  logic [sfd_pkg::BYTE_W-1:0]  check_total;

  assign seen_inc    = seen_r + 8'd1;
  assign seen_total  = {1'b0, seen_inc} + {1'b0, sfd_pkg::HEADER_BYTES};
  assign check_total = check_r ^ rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    check_nxt = check_r;
    type_nxt  = type_r;
    func_nxt  = func_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_LEN: begin
        len_nxt   = rx_byte;
        check_nxt = sfd_pkg::CHECK_SEED ^ rx_byte;
        seen_nxt  = '0;
        if (rx_byte < sfd_pkg::HEADER_BYTES) begin
          // Too short to carry type and function id: reject at once.
          phase_nxt       = PH_HUNT;
          res_valid       = 1'b1;
          res.result_kind = sfd_pkg::KIND_NAK;
          res.reply_byte  = cfg.nak_value;
          res.frame_end   = 1'b1;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_nxt  = rx_byte;
        check_nxt = check_total;
        phase_nxt = PH_FUNC;
      end
      PH_FUNC: begin
        func_nxt  = rx_byte;
        check_nxt = check_total;
        phase_nxt = (len_r == sfd_pkg::HEADER_BYTES) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        check_nxt = check_total;
        seen_nxt  = seen_inc;
        if (seen_total >= {1'b0, len_r}) begin
          phase_nxt = PH_CHECK;
        end
        res_valid        = 1'b1;
        res.result_kind  = sfd_pkg::KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.msg_type     = type_r;
        res.function_id  = func_r;
      end
      PH_CHECK: begin
        check_nxt       = check_total;
        phase_nxt       = PH_HUNT;
        res_valid       = 1'b1;
        res.msg_type    = type_r;
        res.function_id = func_r;
        res.frame_end   = 1'b1;
        if (check_total == '0) begin
          res.result_kind = sfd_pkg::KIND_ACK;
          res.reply_byte  = cfg.ack_value;
        end else begin
          res.result_kind = sfd_pkg::KIND_NAK;
          res.reply_byte  = cfg.nak_value;
        end
      end
      default: begin
        // Hunting, and unused codes behave the same.
        phase_nxt = (rx_byte == cfg.start_marker) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      seen_r  <= '0;
      check_r <= sfd_pkg::CHECK_SEED;
      type_r  <= '0;
      func_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      check_r <= check_nxt;
      type_r  <= type_nxt;
      func_r  <= func_nxt;
    end
  end

endmodule

// ----- rtl/core/sfd_outreg.sv -----
module sfd_outreg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           res_valid,
  input  sfd_pkg::res_t  res,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output sfd_pkg::res_t  out_res
);

  logic          valid_r;
  sfd_pkg::res_t res_r;

  // A new request may enter while the register is empty, or when the held result leaves in the same cycle.
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ----- rtl/core/serial_frame_deframer.sv -----
// A result appears on the out_ side in the cycle after its request is accepted.
// Throughput: one byte per cycle; the input stalls only while a held result is not taken.
// Only the result register can stall the input; the parse state never does.
// Reset (rst_n low at a clock edge) returns to hunting for the start marker, empties the
// result register and restores the configuration registers to their default values.
module serial_frame_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sfd_pkg::KIND_W-1:0]          out_result_kind,
  output logic [sfd_pkg::BYTE_W-1:0]          out_payload_byte,
  output logic [sfd_pkg::BYTE_W-1:0]          out_msg_type,
  output logic [sfd_pkg::BYTE_W-1:0]          out_function_id,
  output logic [sfd_pkg::BYTE_W-1:0]          out_reply_byte,
  output logic                                out_frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]          cfg_data
);

  sfd_pkg::cfg_t cfg;
  sfd_pkg::res_t res;
  sfd_pkg::res_t out_res;
  logic          res_valid;
  logic          can_load;
  logic          take;

  assign in_ready = can_load;
  assign take     = in_valid && can_load;

  sfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_result_kind  = out_res.result_kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_msg_type     = out_res.msg_type;
  assign out_function_id  = out_res.function_id;
  assign out_reply_byte   = out_res.reply_byte;
  assign out_frame_end    = out_res.frame_end;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam logic [sfd_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    SEEK_MARKER,
    GET_LENGTH,
    GET_TYPE,
    GET_FUNC,
    GET_PAYLOAD,
    GET_CHECKSUM
  } parse_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [sfd_pkg::BYTE_W-1:0]      in_rx_byte;
  logic                            out_valid;
  logic                            out_ready;
  logic [sfd_pkg::KIND_W-1:0]      out_result_kind;
  logic [sfd_pkg::BYTE_W-1:0]      out_payload_byte;
  logic [sfd_pkg::BYTE_W-1:0]      out_msg_type;
  logic [sfd_pkg::BYTE_W-1:0]      out_function_id;
  logic [sfd_pkg::BYTE_W-1:0]      out_reply_byte;
  logic                            out_frame_end;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sfd_pkg::BYTE_W-1:0]      cfg_data;

  // Mirror of the parser and its registers, advanced on every accepted request.
  sfd_pkg::cfg_t              cfg_q;
  parse_t                     parse_st;
  logic [sfd_pkg::BYTE_W-1:0] frm_len;
  logic [sfd_pkg::BYTE_W-1:0] pay_count;
  logic [sfd_pkg::BYTE_W-1:0] xor_acc;
  logic [sfd_pkg::BYTE_W-1:0] type_hold;
  logic [sfd_pkg::BYTE_W-1:0] func_hold;

  sfd_pkg::res_t              pending_results[$];
  logic [sfd_pkg::BYTE_W-1:0] pay_q[$];
  logic [sfd_pkg::BYTE_W-1:0] frame_marker;
  int                         err_count;
  bit                         in_gaps_on;
  bit                         out_stalls_on;

  serial_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_msg_type     (out_msg_type),
    .out_function_id  (out_function_id),
    .out_reply_byte   (out_reply_byte),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic deframe_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
    sfd_pkg::res_t r;
    r = '0;
    case (parse_st)
      GET_LENGTH: begin
        frm_len   = b;
        xor_acc   = sfd_pkg::CHECK_SEED ^ b;
        pay_count = '0;
        if (b < sfd_pkg::HEADER_BYTES) begin
          // Too short to hold type and function id: rejected on the spot.
          parse_st      = SEEK_MARKER;
          r.result_kind = sfd_pkg::KIND_NAK;
          r.reply_byte  = cfg_q.nak_value;
          r.frame_end   = 1'b1;
          pending_results.push_back(r);
        end else begin
          parse_st = GET_TYPE;
        end
      end
      GET_TYPE: begin
        type_hold = b;
        xor_acc   = xor_acc ^ b;
        parse_st  = GET_FUNC;
      end
      GET_FUNC: begin
        func_hold = b;
        xor_acc   = xor_acc ^ b;
        parse_st  = (frm_len == sfd_pkg::HEADER_BYTES) ? GET_CHECKSUM : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        xor_acc   = xor_acc ^ b;
        pay_count = pay_count + 8'd1;
        if (int'(pay_count) + int'(sfd_pkg::HEADER_BYTES) >= int'(frm_len)) begin
          parse_st = GET_CHECKSUM;
        end
        r.result_kind  = sfd_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
        r.msg_type     = type_hold;
        r.function_id  = func_hold;
        pending_results.push_back(r);
      end
      GET_CHECKSUM: begin
        xor_acc       = xor_acc ^ b;
        parse_st      = SEEK_MARKER;
        r.msg_type    = type_hold;
        r.function_id = func_hold;
        r.frame_end   = 1'b1;
        if (xor_acc == '0) begin
          r.result_kind = sfd_pkg::KIND_ACK;
          r.reply_byte  = cfg_q.ack_value;
        end else begin
          r.result_kind = sfd_pkg::KIND_NAK;
          r.reply_byte  = cfg_q.nak_value;
        end
        pending_results.push_back(r);
      end
      default: begin
        if (b == cfg_q.start_marker) begin
          parse_st = GET_LENGTH;
        end else begin
          parse_st = SEEK_MARKER;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [sfd_pkg::BYTE_W-1:0] want,
                             input logic [sfd_pkg::BYTE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_result();
    sfd_pkg::res_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got kind %h byte %h reply %h",
               $time, out_result_kind, out_payload_byte, out_reply_byte);
      err_count++;
    end else begin
      e = pending_results.pop_front();
      check_field("result_kind", 8'(e.result_kind), 8'(out_result_kind));
      check_field("payload_byte", e.payload_byte, out_payload_byte);
      check_field("msg_type", e.msg_type, out_msg_type);
      check_field("function_id", e.function_id, out_function_id);
      check_field("reply_byte", e.reply_byte, out_reply_byte);
      check_field("frame_end", 8'(e.frame_end), 8'(out_frame_end));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        check_result();
      end
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfd_pkg::REG_START_MARKER: cfg_q.start_marker = cfg_data;
          sfd_pkg::REG_ACK_VALUE:    cfg_q.ack_value = cfg_data;
          sfd_pkg::REG_NAK_VALUE:    cfg_q.nak_value = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result side: random stall bursts while enabled, otherwise always ready.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (out_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Valid is left high on return so that back-to-back requests need no second assignment.
  task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
    logic got;
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(negedge clk);
      got = in_ready;
      @(posedge clk);
    end while (!got);
  endtask

  task automatic send_frame(input logic [sfd_pkg::BYTE_W-1:0] len,
                            input logic [sfd_pkg::BYTE_W-1:0] typ,
                            input logic [sfd_pkg::BYTE_W-1:0] fn, input bit corrupt);
    logic [sfd_pkg::BYTE_W-1:0] sum;
    logic [sfd_pkg::BYTE_W-1:0] b;
    sum = sfd_pkg::CHECK_SEED ^ len;
    send_byte(frame_marker);
    send_byte(len);
    if (len >= sfd_pkg::HEADER_BYTES) begin
      send_byte(typ);
      send_byte(fn);
      sum = sum ^ typ ^ fn;
      for (int i = 0; i < int'(len) - int'(sfd_pkg::HEADER_BYTES); i++) begin
        if (pay_q.size() != 0) begin
          b = pay_q.pop_front();
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        sum = sum ^ b;
        send_byte(b);
      end
      if (corrupt) begin
        sum = sum ^ 8'($urandom_range(1, 255));
      end
      send_byte(sum);
    end
  endtask

  // Checked at the falling edge, after the monitor has handled the rising one.
  task automatic wait_results_done();
    int n;
    n = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sfd_pkg::BYTE_W-1:0] val);
    logic got;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      got = cfg_ready;
      @(posedge clk);
    end while (!got);
  endtask

  task automatic set_regs(input logic [sfd_pkg::BYTE_W-1:0] marker,
                          input logic [sfd_pkg::BYTE_W-1:0] ack,
                          input logic [sfd_pkg::BYTE_W-1:0] nak);
    wait_results_done();
    write_reg(sfd_pkg::REG_START_MARKER, marker);
    write_reg(sfd_pkg::REG_ACK_VALUE, ack);
    write_reg(sfd_pkg::REG_NAK_VALUE, nak);
    // The fourth index has no register behind it and must leave the others alone.
    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_valid    <= 1'b0;
    frame_marker = marker;
  endtask

  task automatic test_reset_defaults();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(8'd3, 8'hff, 8'h00, 1'b0);
    send_frame(8'd0, 8'h00, 8'h00, 1'b0);
    send_frame(8'd1, 8'h00, 8'h00, 1'b0);
    send_frame(8'd2, 8'h00, 8'h00, 1'b0);
    pay_q.push_back(8'h00);
    pay_q.push_back(8'hff);
    pay_q.push_back(frame_marker);
    send_frame(8'd6, 8'h00, 8'hff, 1'b0);
    send_frame(8'd4, 8'h5a, 8'ha5, 1'b1);
  endtask

  task automatic test_register_settings();
    set_regs(8'h00, 8'hff, 8'h00);
    send_byte(8'h7e);
    pay_q.push_back(8'h00);
    send_frame(8'd5, 8'h81, 8'h18, 1'b0);
    send_frame(8'd4, 8'h3c, 8'hc3, 1'b1);
    send_frame(8'd2, 8'h00, 8'h00, 1'b0);
    set_regs(8'hff, 8'h00, 8'hff);
    pay_q.push_back(8'hff);
    send_frame(8'd4, 8'h0f, 8'hf0, 1'b0);
    send_frame(8'd3, 8'h11, 8'h22, 1'b1);
    send_frame(8'd1, 8'h00, 8'h00, 1'b0);
    set_regs(sfd_pkg::START_MARKER_RST, sfd_pkg::ACK_VALUE_RST, sfd_pkg::NAK_VALUE_RST);
    send_frame(8'd7, 8'h42, 8'h24, 1'b0);
  endtask

  task automatic test_random_frames();
    int sent;
    int next_cfg;
    int pick;
    int n_extra;
    logic [sfd_pkg::BYTE_W-1:0] len;
    sent          = 0;
    next_cfg      = 350;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    while (sent < 1450) begin
      if (sent >= next_cfg) begin
        set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
        next_cfg += 350;
      end
      n_extra = $urandom_range(0, 2);
      repeat (n_extra) send_byte(8'($urandom_range(0, 255)));
      sent += n_extra;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        len = 8'($urandom_range(0, 2));
      end else if (pick < 8) begin
        // Cut short: later bytes are swallowed as the rest of this frame.
        send_byte(frame_marker);
        send_byte(8'($urandom_range(3, 20)));
        send_byte(8'($urandom_range(0, 255)));
        sent += 3;
        continue;
      end else if (pick < 9) begin
        len = 8'($urandom_range(200, 255));
      end else begin
        len = 8'($urandom_range(3, 12));
      end
      send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 9) == 0);
      sent += (len < sfd_pkg::HEADER_BYTES) ? 2 : int'(len) + 2;
    end
  endtask

  task automatic test_full_rate();
    int sent;
    logic [sfd_pkg::BYTE_W-1:0] len;
    sent = 0;
    wait_results_done();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    while (sent < 250) begin
      len = 8'($urandom_range(0, 10));
      send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 7) == 0);
      sent += (len < sfd_pkg::HEADER_BYTES) ? 2 : int'(len) + 2;
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= sfd_pkg::REG_START_MARKER;
    cfg_data   <= '0;
    err_count     = 0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    frame_marker  = sfd_pkg::START_MARKER_RST;
    cfg_q         = '{sfd_pkg::START_MARKER_RST, sfd_pkg::ACK_VALUE_RST,
                      sfd_pkg::NAK_VALUE_RST};
    parse_st      = SEEK_MARKER;
    frm_len       = '0;
    pay_count     = '0;
    xor_acc       = sfd_pkg::CHECK_SEED;
    type_hold     = '0;
    func_hold     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_settings();
    test_random_frames();
    test_full_rate();

    wait_results_done();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results expected but never delivered", $time,
               pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
